/* src/tfs_pkg.sv */
// Shared types and constants for the timed frame sequencer.
package tfs_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int DELTA_W     = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COUNT    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PERIOD   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_MODE      = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BACKWARD = 8'd3;

   localparam logic [4:0]  FRAME_COUNT_RESET    = 5'd2;
   localparam logic [15:0] FRAME_PERIOD_RESET   = 16'd250;
   localparam logic        WRAP_MODE_RESET      = 1'b1;
   localparam logic        START_BACKWARD_RESET = 1'b0;

   localparam logic [31:0]        BIG_GAP_LIMIT  = 32'd2000;
   localparam logic [DELTA_W-1:0] BIG_GAP_CREDIT = 11'd256;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic        func;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [3:0] frame_index;
      logic       reversed_now;
      logic       frame_changed;
   } rsp_type;

endpackage

/* src/tfs_alu.sv */
// Shared 32-bit add and subtract unit for elapsed time and step time.
module tfs_alu
   import tfs_pkg::*;
(
   input  alu_op_type  op,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);

   always_comb begin
      unique case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         default: y = a + b;
      endcase
   end

endmodule

/* src/tfs_frame_step.sv */
// Next frame and direction for one animation step in wrap or bounce mode.
module tfs_frame_step
   import tfs_pkg::*;
#(
   parameter int FW = 4,
   parameter int CW = 5
)
(
   input  logic [FW-1:0] frame_cur,
   input  logic          dir_cur,
   input  logic [CW-1:0] cnt,
   input  logic          wrap,
   output logic [FW-1:0] frame_nxt,
   output logic          dir_nxt
);

   logic [CW-1:0] frame_ext;
   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] cnt_m2;

   assign frame_ext = CW'(frame_cur);
   assign cnt_m1    = cnt - CW'(1);
   assign cnt_m2    = cnt - CW'(2);

   always_comb begin
      frame_nxt = frame_cur;
      dir_nxt   = dir_cur;
      if (dir_cur) begin
         if (frame_cur != '0) begin
            frame_nxt = frame_cur - FW'(1);
         end else if (wrap) begin
            frame_nxt = cnt_m1[FW-1:0];
         end else begin
            frame_nxt = FW'(1);
            dir_nxt   = ~dir_cur;
         end
      end else begin
         if (frame_ext < cnt_m1) begin
            frame_nxt = frame_cur + FW'(1);
         end else if (wrap) begin
            frame_nxt = '0;
         end else begin
            frame_nxt = cnt_m2[FW-1:0];
            dir_nxt   = ~dir_cur;
         end
      end
   end

endmodule

/* src/timed_frame_sequencer.sv */
// A restart goes from acceptance straight to the done state; an advance passes through the
// calculate state and the step state, which takes N frame steps, before the done state.
// N is at most 1999 (an elapsed time of 2000 with a period of 1); the step loop takes one
// frame step per cycle while the shared 32-bit adder advances the last step time.
// The done state hands the result to the output register; the input stalls until idle again.
// Reset is synchronous and active high; it restores the register defaults and clears state.
module timed_frame_sequencer
   import tfs_pkg::*;
#(
   parameter int MAX_FRAME_COUNT = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   // The frame register holds values up to MAX_FRAME_COUNT-1. The count needs room for
   // both the 5-bit register and the clamp limit.
   localparam int FW = (MAX_FRAME_COUNT > 2) ? $clog2(MAX_FRAME_COUNT) : 1;
   localparam int CW = ($clog2(MAX_FRAME_COUNT + 1) > 5) ? $clog2(MAX_FRAME_COUNT + 1) : 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_STEP,
      ST_DONE
   } state_type;

   // Configuration registers. Writes must arrive only while the block is idle; the block does not enforce it.
   logic [4:0]  count_ff;
   logic [15:0] period_ff;
   logic        wrap_ff;
   logic        start_back_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= FRAME_COUNT_RESET;
         period_ff     <= FRAME_PERIOD_RESET;
         wrap_ff       <= WRAP_MODE_RESET;
         start_back_ff <= START_BACKWARD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_COUNT:    count_ff      <= csr_wdata[4:0];
            CSR_FRAME_PERIOD:   period_ff     <= csr_wdata[15:0];
            CSR_WRAP_MODE:      wrap_ff       <= csr_wdata[0];
            CSR_START_BACKWARD: start_back_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective count, clamped to 2..MAX_FRAME_COUNT, and a zero period read as one.
   logic [CW-1:0] count_ext;
   logic [CW-1:0] cnt_used;
   logic [15:0]   period_used;

   assign count_ext   = CW'(count_ff);
   assign period_used = (period_ff == '0) ? 16'd1 : period_ff;

   always_comb begin
      cnt_used = count_ext;
      if (count_ext < CW'(2)) begin
         cnt_used = CW'(2);
      end else if (count_ext > CW'(MAX_FRAME_COUNT)) begin
         cnt_used = CW'(MAX_FRAME_COUNT);
      end
   end

   // Sequencer state and datapath registers.
   state_type          state_ff, state_in;
   logic [FW-1:0]      frame_ff, frame_in;
   logic               dir_ff, dir_in;
   logic [31:0]        last_ff, last_in;
   logic [31:0]        now_ff, now_in;
   logic [DELTA_W-1:0] dcnt_ff, dcnt_in;
   logic               changed_ff, changed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // The one adder is shared: it forms the elapsed time in the calculate state and
   // advances the last step time by one period in each step.
   alu_op_type  alu_op;
   logic [31:0] alu_a;
   logic [31:0] alu_b;
   logic [31:0] alu_y;

   always_comb begin
      if (state_ff == ST_CALC) begin
         alu_op = ALU_SUB;
         alu_a  = now_ff;
         alu_b  = last_ff;
      end else begin
         alu_op = ALU_ADD;
         alu_a  = last_ff;
         alu_b  = {16'd0, period_used};
      end
   end

   tfs_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   logic [FW-1:0] frame_nxt;
   logic          dir_nxt;

   tfs_frame_step #(
      .FW (FW),
      .CW (CW)
   ) u_frame_step (
      .frame_cur (frame_ff),
      .dir_cur   (dir_ff),
      .cnt       (cnt_used),
      .wrap      (wrap_ff),
      .frame_nxt (frame_nxt),
      .dir_nxt   (dir_nxt)
   );

   // A step is taken while the remaining elapsed time is strictly above the period.
   logic        step_go;
   logic [15:0] dcnt_sub;

   assign step_go  = {5'd0, dcnt_ff} > period_used;
   assign dcnt_sub = {5'd0, dcnt_ff} - period_used;

   // The frame register is padded so the result can always take its low four bits.
   logic [FW+3:0] frame_pad;

   assign frame_pad = {4'd0, frame_ff};

   logic req_take;
   logic rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      frame_in     = frame_ff;
      dir_in       = dir_ff;
      last_in      = last_ff;
      now_in       = now_ff;
      dcnt_in      = dcnt_ff;
      changed_in   = changed_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               now_in     = req_data.now_time;
               changed_in = 1'b0;
               if (req_data.func) begin
                  frame_in = '0;
                  dir_in   = start_back_ff;
                  last_in  = req_data.now_time;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            // A negative elapsed time counts as zero; a large gap is credited a fixed
            // amount. Either way the last step time restarts at the current time.
            if (alu_y[31]) begin
               last_in = now_ff;
               dcnt_in = '0;
            end else if (alu_y > BIG_GAP_LIMIT) begin
               last_in = now_ff;
               dcnt_in = BIG_GAP_CREDIT;
            end else begin
               dcnt_in = alu_y[DELTA_W-1:0];
            end
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (step_go) begin
               dcnt_in    = dcnt_sub[DELTA_W-1:0];
               frame_in   = frame_nxt;
               dir_in     = dir_nxt;
               last_in    = alu_y;
               changed_in = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The output register takes the result as soon as it is empty or being read.
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.frame_index   = frame_pad[3:0];
               rsp_data_in.reversed_now  = dir_ff;
               rsp_data_in.frame_changed = changed_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= '0;
         dir_ff       <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         dir_ff       <= dir_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      dcnt_ff     <= dcnt_in;
      changed_ff  <= changed_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The remaining elapsed time never exceeds the large-gap limit while stepping.
   a_dcnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> ({21'd0, dcnt_ff} <= BIG_GAP_LIMIT))
      else $error("elapsed time counter above limit while stepping");

   // Every step strictly shrinks the remaining elapsed time, so the loop ends.
   a_step_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && step_go) |=> (dcnt_ff < $past(dcnt_ff)))
      else $error("step did not reduce elapsed time");

   // A restart goes straight to the result with frame zero and no step reported.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.func) |=> (state_ff == ST_DONE && frame_ff == '0 && !changed_ff))
      else $error("restart did not clear the frame");

endmodule
